// ===== rtl/core/jsr_pkg.sv =====
package jsr_pkg;

   // grid geometry and sample format
   localparam int MAX_WIDTH   = 1024;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int SAMPLE_BITS = 24;
   localparam int SUM_W       = SAMPLE_BITS + 2;
   localparam int DIFF_W      = SAMPLE_BITS + 1;
   localparam int SQ_W        = 2 * SAMPLE_BITS + 1;

   // register and field widths
   localparam int GW_W       = 11;
   localparam int GH_W       = 16;
   localparam int ROW_W      = 16;
   localparam int COL_W      = ADDR_W;
   localparam int RES_W      = 63;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register reset values and minimum grid size
   localparam logic [GW_W-1:0] GW_RESET = GW_W'(1024);
   localparam logic [GH_W-1:0] GH_RESET = GH_W'(1024);
   localparam logic [GW_W-1:0] GW_MIN   = GW_W'(3);
   localparam logic [GH_W-1:0] GH_MIN   = GH_W'(3);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_RESIDUAL_ENABLE = CSR_IDX_W'(2);

   // response buffer
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] new_value;
      logic [ROW_W-1:0]              out_row;
      logic [COL_W-1:0]              out_col;
      logic [RES_W-1:0]              residual;
      logic                          grid_last;
   } rsp_word_type;

endpackage

// ===== rtl/core/jsr_if.sv =====
interface jsr_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [jsr_pkg::SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface jsr_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [jsr_pkg::SAMPLE_BITS-1:0] new_value;
   logic [jsr_pkg::ROW_W-1:0]              out_row;
   logic [jsr_pkg::COL_W-1:0]              out_col;
   logic [jsr_pkg::RES_W-1:0]              residual;
   logic                                   grid_last;

   modport source (output valid, output new_value, output out_row, output out_col,
                   output residual, output grid_last, input ready);
   modport sink (input valid, input new_value, input out_row, input out_col,
                 input residual, input grid_last, output ready);
endinterface

interface jsr_csr_if;
   logic                              valid;
   logic                              ready;
   logic [jsr_pkg::CSR_IDX_W-1:0]     reg_index;
   logic [jsr_pkg::CSR_DATA_W-1:0]    wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== rtl/core/jacobi_stencil_residual.sv =====
// channel   | dir | payload                                        | handshake
// ----------+-----+------------------------------------------------+-------------
// req_bus   | in  | sample (s24, q12.12)                           | valid/ready
// rsp_bus   | out | new_value, out_row, out_col, residual, grid_last| valid/ready
// csr_bus   | in  | reg_index, wr_data                             | valid/ready
//
// one sample word per cycle while req ready is high; a response word goes through
// read, sum, square and accumulate after the sample that completes its bottom neighbor
// reset starts a clearing pass over all 1024 entries of both line memories; req ready
// stays low during it, csr writes are taken throughout
// every csr write outside the clearing pass goes through the prime and load states, in
// which the center of the next column is fetched again from the line memory
// a 4-word response buffer with credit accounting decouples rsp stalls from the sample
// stream; req ready drops outside the run state and when that buffer could overflow
module jacobi_stencil_residual (
   input  logic           clock,
   input  logic           reset,
   jsr_req_if.sink        req_bus,
   jsr_rsp_if.source      rsp_bus,
   jsr_csr_if.sink        csr_bus
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_PRIME = 4'b0010,
      ST_LOAD  = 4'b0100,
      ST_RUN   = 4'b1000
   } state_type;

   localparam int SB = jsr_pkg::SAMPLE_BITS;
   localparam int AW = jsr_pkg::ADDR_W;
   localparam int GW = jsr_pkg::GW_W;
   localparam int GH = jsr_pkg::GH_W;

   state_type state_ff, state_in;

   // configuration registers
   logic [GW-1:0] grid_width_ff;
   logic [GH-1:0] grid_height_ff;
   logic          residual_enable_ff;

   // raster position and clearing sweep
   logic [AW-1:0]              col_ff;
   logic [jsr_pkg::ROW_W-1:0]  row_ff;
   logic [AW-1:0]              clr_ff;

   // window registers: center of the current column and its left neighbor
   logic signed [SB-1:0] center_ff;
   logic signed [SB-1:0] left_ff;

   // memory ports
   logic          la_we, lt_we;
   logic [AW-1:0] la_waddr, la_raddr, lt_waddr;
   logic [SB-1:0] la_wdata, lt_wdata, la_rdata, lt_rdata;

   // stage 2: memory data back
   logic                        v2_ff, emit2_ff, clear2_ff, last2_ff;
   logic signed [SB-1:0]        s2_sample_ff;
   logic [AW-1:0]               s2_col_ff;
   logic [jsr_pkg::ROW_W-1:0]   s2_row_ff;

   // stage 3: square
   logic                        emit3_ff, clear3_ff, last3_ff;
   logic signed [SB-1:0]        s3_new_ff;
   logic signed [jsr_pkg::DIFF_W-1:0] s3_diff_ff;
   logic [AW-1:0]               s3_col_ff;
   logic [jsr_pkg::ROW_W-1:0]   s3_row_ff;

   // stage 4: accumulate
   logic                        emit4_ff, clear4_ff, last4_ff;
   logic signed [SB-1:0]        s4_new_ff;
   logic [jsr_pkg::SQ_W-1:0]    s4_sq_ff;
   logic [AW-1:0]               s4_col_ff;
   logic [jsr_pkg::ROW_W-1:0]   s4_row_ff;

   logic [jsr_pkg::RES_W-1:0]   acc_ff, acc_in;

   // effective geometry
   logic [GW-1:0]  w_eff;
   logic [GH-1:0]  h_eff;
   logic [AW-1:0]  c_eff, next_col;
   logic [jsr_pkg::ROW_W-1:0] r_eff;
   logic [GW-1:0]  c_plus;
   logic [GH:0]    r_plus;
   logic           row_end, interior, grid_end, grid_start;

   logic           csr_wr, req_acc;
   logic [jsr_pkg::RSP_CNT_W-1:0] rsp_count;
   logic [jsr_pkg::RSP_CNT_W+1:0] credit_use;
   logic           rsp_pop;

   logic signed [jsr_pkg::SUM_W-1:0]  nb_sum;
   logic signed [SB-1:0]              new2;
   logic signed [jsr_pkg::DIFF_W-1:0] diff2;
   logic signed [2*jsr_pkg::DIFF_W-1:0] prod3;
   logic [jsr_pkg::RES_W:0]           acc_sum;
   logic [jsr_pkg::RES_W-1:0]         acc_base, acc_new;
   jsr_pkg::rsp_word_type             push_word, head_word;

   assign csr_bus.ready = 1'b1;
   assign csr_wr        = csr_bus.valid && csr_bus.ready;

   // clamp the registers the way the grid is walked
   always_comb begin
      w_eff = grid_width_ff;
      if (grid_width_ff < jsr_pkg::GW_MIN) begin
         w_eff = jsr_pkg::GW_MIN;
      end else if (grid_width_ff > GW'(jsr_pkg::MAX_WIDTH)) begin
         w_eff = GW'(jsr_pkg::MAX_WIDTH);
      end
      h_eff = (grid_height_ff < jsr_pkg::GH_MIN) ? jsr_pkg::GH_MIN : grid_height_ff;
   end

   // position of the incoming sample, wrapped if the grid shrank
   always_comb begin
      c_eff      = ({1'b0, col_ff} >= w_eff) ? '0 : col_ff;
      r_eff      = (row_ff >= h_eff) ? '0 : row_ff;
      c_plus     = {1'b0, c_eff} + 1'b1;
      r_plus     = {1'b0, r_eff} + 1'b1;
      row_end    = (c_plus >= w_eff);
      next_col   = row_end ? '0 : c_plus[AW-1:0];
      interior   = (r_eff >= jsr_pkg::ROW_W'(2)) && (c_eff != '0)
                   && ({1'b0, c_eff} <= w_eff - GW'(2));
      grid_end   = (r_eff == h_eff - 1'b1) && ({1'b0, c_eff} == w_eff - GW'(2));
      grid_start = (r_eff == '0) && (c_eff == '0);
   end

   // credit: buffered words plus words still in flight must leave a slot
   assign rsp_pop    = rsp_bus.valid && rsp_bus.ready;
   assign credit_use = (jsr_pkg::RSP_CNT_W+2)'(rsp_count)
                     + (jsr_pkg::RSP_CNT_W+2)'(emit2_ff)
                     + (jsr_pkg::RSP_CNT_W+2)'(emit3_ff)
                     + (jsr_pkg::RSP_CNT_W+2)'(emit4_ff)
                     - (jsr_pkg::RSP_CNT_W+2)'(rsp_pop);
   assign req_bus.ready = (state_ff == ST_RUN)
                        && (credit_use <= (jsr_pkg::RSP_CNT_W+2)'(jsr_pkg::RSP_DEPTH - 1));
   assign req_acc = req_bus.valid && req_bus.ready;

   // control sequence
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(jsr_pkg::MAX_WIDTH - 1)) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = csr_wr ? ST_PRIME : ST_RUN;
         end
         ST_RUN: begin
            if (csr_wr) begin
               state_in = ST_PRIME;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      if (csr_wr && (state_ff == ST_PRIME)) begin
         state_in = ST_PRIME;
      end
   end

   // line memory ports
   always_comb begin
      la_we    = 1'b0;
      la_waddr = c_eff;
      la_wdata = req_bus.sample;
      lt_we    = v2_ff;
      lt_waddr = s2_col_ff;
      lt_wdata = center_ff;
      // prime fetches the center of the upcoming column, run fetches the next one
      la_raddr = (state_ff == ST_PRIME) ? c_eff : next_col;
      if (state_ff == ST_CLEAR) begin
         la_we    = 1'b1;
         la_waddr = clr_ff;
         la_wdata = '0;
         lt_we    = 1'b1;
         lt_waddr = clr_ff;
         lt_wdata = '0;
      end else if (req_acc) begin
         la_we = 1'b1;
      end
   end

   jsr_ram #(
      .WIDTH (SB),
      .DEPTH (jsr_pkg::MAX_WIDTH)
   ) u_line_above (
      .clock (clock),
      .we    (la_we),
      .waddr (la_waddr),
      .wdata (la_wdata),
      .raddr (la_raddr),
      .rdata (la_rdata)
   );

   jsr_ram #(
      .WIDTH (SB),
      .DEPTH (jsr_pkg::MAX_WIDTH)
   ) u_line_two_above (
      .clock (clock),
      .we    (lt_we),
      .waddr (lt_waddr),
      .wdata (lt_wdata),
      .raddr (c_eff),
      .rdata (lt_rdata)
   );

   // stage 2 arithmetic: right neighbor is the fetched next column
   always_comb begin
      nb_sum = jsr_pkg::SUM_W'(left_ff) + jsr_pkg::SUM_W'($signed(la_rdata))
             + jsr_pkg::SUM_W'($signed(lt_rdata)) + jsr_pkg::SUM_W'(s2_sample_ff);
      new2   = SB'(nb_sum >>> 2);
      diff2  = jsr_pkg::DIFF_W'(new2) - jsr_pkg::DIFF_W'(center_ff);
   end

   assign prod3 = s3_diff_ff * s3_diff_ff;

   // stage 4: saturating accumulate, grid start clears
   always_comb begin
      acc_base = clear4_ff ? '0 : acc_ff;
      acc_sum  = {1'b0, acc_base} + (jsr_pkg::RES_W+1)'(s4_sq_ff);
      acc_new  = acc_sum[jsr_pkg::RES_W] ? '1 : acc_sum[jsr_pkg::RES_W-1:0];
      acc_in   = acc_base;
      if (emit4_ff && residual_enable_ff) begin
         acc_in = acc_new;
      end
      push_word.new_value = s4_new_ff;
      push_word.out_row   = s4_row_ff;
      push_word.out_col   = s4_col_ff;
      push_word.residual  = residual_enable_ff ? acc_new : '0;
      push_word.grid_last = last4_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_CLEAR;
         clr_ff             <= '0;
         col_ff             <= '0;
         row_ff             <= '0;
         grid_width_ff      <= jsr_pkg::GW_RESET;
         grid_height_ff     <= jsr_pkg::GH_RESET;
         residual_enable_ff <= 1'b1;
         v2_ff              <= 1'b0;
         emit2_ff           <= 1'b0;
         emit3_ff           <= 1'b0;
         emit4_ff           <= 1'b0;
         clear2_ff          <= 1'b0;
         clear3_ff          <= 1'b0;
         clear4_ff          <= 1'b0;
         acc_ff             <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (csr_wr) begin
            case (csr_bus.reg_index)
               jsr_pkg::CSR_GRID_WIDTH:      grid_width_ff <= csr_bus.wr_data[GW-1:0];
               jsr_pkg::CSR_GRID_HEIGHT:     grid_height_ff <= csr_bus.wr_data[GH-1:0];
               jsr_pkg::CSR_RESIDUAL_ENABLE: residual_enable_ff <= csr_bus.wr_data[0];
               default: ;
            endcase
         end
         if (req_acc) begin
            col_ff <= next_col;
            if (row_end) begin
               row_ff <= (r_plus >= {1'b0, h_eff}) ? '0 : r_plus[jsr_pkg::ROW_W-1:0];
            end else begin
               row_ff <= r_eff;
            end
         end
         v2_ff     <= req_acc;
         emit2_ff  <= req_acc && interior;
         clear2_ff <= req_acc && grid_start;
         emit3_ff  <= emit2_ff;
         clear3_ff <= clear2_ff;
         emit4_ff  <= emit3_ff;
         clear4_ff <= clear3_ff;
         if (emit4_ff || clear4_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOAD) begin
         center_ff <= $signed(la_rdata);
      end else if (v2_ff) begin
         left_ff   <= center_ff;
         center_ff <= $signed(la_rdata);
      end
      if (req_acc) begin
         s2_sample_ff <= req_bus.sample;
         s2_col_ff    <= c_eff;
         s2_row_ff    <= r_eff - 1'b1;
         last2_ff     <= grid_end;
      end
      s3_new_ff  <= new2;
      s3_diff_ff <= diff2;
      s3_col_ff  <= s2_col_ff;
      s3_row_ff  <= s2_row_ff;
      last3_ff   <= last2_ff;
      s4_new_ff  <= s3_new_ff;
      s4_sq_ff   <= prod3[jsr_pkg::SQ_W-1:0];
      s4_col_ff  <= s3_col_ff;
      s4_row_ff  <= s3_row_ff;
      last4_ff   <= last3_ff;
   end

   jsr_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (emit4_ff),
      .push_word (push_word),
      .pop       (rsp_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_word  (head_word),
      .count     (rsp_count)
   );

   assign rsp_bus.new_value = head_word.new_value;
   assign rsp_bus.out_row   = head_word.out_row;
   assign rsp_bus.out_col   = head_word.out_col;
   assign rsp_bus.residual  = head_word.residual;
   assign rsp_bus.grid_last = head_word.grid_last;

endmodule

// ===== rtl/core/jsr_ram.sv =====
module jsr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // read-first, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

// ===== rtl/core/jsr_rsp_fifo.sv =====
module jsr_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  jsr_pkg::rsp_word_type             push_word,
   input  logic                              pop,
   output logic                              out_valid,
   output jsr_pkg::rsp_word_type             out_word,
   output logic [jsr_pkg::RSP_CNT_W-1:0]     count
);

   jsr_pkg::rsp_word_type                 slot_ff [jsr_pkg::RSP_DEPTH];
   logic [jsr_pkg::RSP_PTR_W-1:0]         wr_ptr_ff;
   logic [jsr_pkg::RSP_PTR_W-1:0]         rd_ptr_ff;
   logic [jsr_pkg::RSP_CNT_W-1:0]         count_ff;
   logic                                  do_pop;

   assign out_valid = (count_ff != '0);
   assign out_word  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign do_pop    = pop && out_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/core/jsr_checker.sv =====
module jsr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [jsr_pkg::SAMPLE_BITS-1:0] rsp_new_value,
   input logic [jsr_pkg::ROW_W-1:0]         rsp_out_row,
   input logic [jsr_pkg::COL_W-1:0]         rsp_out_col,
   input logic [jsr_pkg::RES_W-1:0]         rsp_residual
);

   // clearing pass holds off samples right after reset
   a_no_req_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req ready high right after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // interior points only
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_row != '0) && (rsp_out_col != '0))
      else $error("boundary point on rsp");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_value)
                                  && $stable(rsp_residual))
      else $error("rsp word dropped or changed while stalled");

endmodule

bind jacobi_stencil_residual jsr_checker u_jsr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_new_value (rsp_bus.new_value),
   .rsp_out_row   (rsp_bus.out_row),
   .rsp_out_col   (rsp_bus.out_col),
   .rsp_residual  (rsp_bus.residual)
);
